// ----- src/orb_pkg.sv -----
package orb_pkg;

  // Defaults for the top-level parameters
  localparam int COORD_BITS_DEF = 12;
  localparam int SINE_FRAC_DEF  = 15;
  localparam int SINE_W_MAX     = 21;

  // Fixed field widths
  localparam int REQ_W     = 2;
  localparam int YAW_W     = 10;
  localparam int PITCH_W   = 8;
  localparam int RAD_W     = 16;
  localparam int STEP_W    = 16;
  localparam int POS_W     = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam int ANG_W     = 12;

  // Angle and range limits
  localparam int YAW_LIM   = 360;
  localparam int QTR       = 90;
  localparam int HALF_TURN = 180;
  localparam int THREE_QTR = 270;
  localparam int PITCH_MIN = 1;
  localparam int PITCH_MAX = 177;
  localparam int RAD_MIN   = 1;
  localparam int RAD_MAX   = 65535;

  localparam int HOME_YAW_DEF    = 0;
  localparam int HOME_PITCH_DEF  = 90;
  localparam int HOME_RADIUS_DEF = 1000;

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef enum logic [REQ_W-1:0] {
    REQ_MOVE    = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_ZOOM    = 2'd2,
    REQ_HOME    = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HOME_YAW    = 2'd0,
    CFG_HOME_PITCH  = 2'd1,
    CFG_HOME_RADIUS = 2'd2
  } cfg_idx_t;

  // Micro-operations driven into the datapath
  typedef enum logic [3:0] {
    OP_NOP,
    OP_RED_MUL,
    OP_RED_SUB,
    OP_RED_FIX,
    OP_LOOKUP,
    OP_MUL_SPSY,
    OP_MUL_SPCY,
    OP_MUL_X,
    OP_MUL_Z,
    OP_MUL_Y,
    OP_EMIT
  } op_t;

  typedef enum logic {
    JMP_NONE,
    JMP_YAW_OK
  } jmp_t;

  localparam int UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t UPC_RED_MUL  = 4'd0;
  localparam upc_t UPC_RED_SUB  = 4'd1;
  localparam upc_t UPC_RED_FIX  = 4'd2;
  localparam upc_t UPC_LOOKUP   = 4'd3;
  localparam upc_t UPC_MUL_SPSY = 4'd4;
  localparam upc_t UPC_MUL_SPCY = 4'd5;
  localparam upc_t UPC_MUL_X    = 4'd6;
  localparam upc_t UPC_MUL_Z    = 4'd7;
  localparam upc_t UPC_MUL_Y    = 4'd8;
  localparam upc_t UPC_EMIT     = 4'd9;
  localparam upc_t UPC_LAST     = UPC_EMIT;

  typedef struct packed {
    op_t  op;
    jmp_t jmp;
    upc_t target;
    logic last;
  } uword_t;

  typedef struct packed {
    logic active;
    op_t  op;
  } ctl_t;

  typedef struct packed {
    logic yaw_in_range;
  } stat_t;

  typedef struct packed {
    logic       neg;
    logic [6:0] idx;
  } sine_sel_t;

  typedef logic [SINE_W_MAX-1:0] sine_tab_t [0:QTR];

  // Control store
  function automatic uword_t ucode(input upc_t pc);
    uword_t w;
    w = '{op: OP_NOP, jmp: JMP_NONE, target: UPC_RED_MUL, last: 1'b1};
    case (pc)
      UPC_RED_MUL:  w = '{op: OP_RED_MUL,  jmp: JMP_YAW_OK, target: UPC_LOOKUP,  last: 1'b0};
      UPC_RED_SUB:  w = '{op: OP_RED_SUB,  jmp: JMP_NONE,   target: UPC_RED_MUL, last: 1'b0};
      UPC_RED_FIX:  w = '{op: OP_RED_FIX,  jmp: JMP_NONE,   target: UPC_RED_MUL, last: 1'b0};
      UPC_LOOKUP:   w = '{op: OP_LOOKUP,   jmp: JMP_NONE,   target: UPC_RED_MUL, last: 1'b0};
      UPC_MUL_SPSY: w = '{op: OP_MUL_SPSY, jmp: JMP_NONE,   target: UPC_RED_MUL, last: 1'b0};
      UPC_MUL_SPCY: w = '{op: OP_MUL_SPCY, jmp: JMP_NONE,   target: UPC_RED_MUL, last: 1'b0};
      UPC_MUL_X:    w = '{op: OP_MUL_X,    jmp: JMP_NONE,   target: UPC_RED_MUL, last: 1'b0};
      UPC_MUL_Z:    w = '{op: OP_MUL_Z,    jmp: JMP_NONE,   target: UPC_RED_MUL, last: 1'b0};
      UPC_MUL_Y:    w = '{op: OP_MUL_Y,    jmp: JMP_NONE,   target: UPC_RED_MUL, last: 1'b0};
      UPC_EMIT:     w = '{op: OP_EMIT,     jmp: JMP_NONE,   target: UPC_RED_MUL, last: 1'b1};
      default:      w = '{op: OP_NOP,      jmp: JMP_NONE,   target: UPC_RED_MUL, last: 1'b1};
    endcase
    return w;
  endfunction

  // term / ((2n)(2n+1)), rounded
  function automatic longint unsigned div_pair(input int unsigned n,
                                               input longint unsigned t);
    case (n)
      1:       return (t + 3) / 6;
      2:       return (t + 10) / 20;
      3:       return (t + 21) / 42;
      4:       return (t + 36) / 72;
      5:       return (t + 55) / 110;
      6:       return (t + 78) / 156;
      7:       return (t + 105) / 210;
      8:       return (t + 136) / 272;
      9:       return (t + 171) / 342;
      default: return (t + 210) / 420;
    endcase
  endfunction

  // Q30 sine of a whole degree in 0..90, Taylor series; elaboration only
  function automatic longint unsigned quarter_sine_q30(input int unsigned a);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    if (a == 0) return 64'd0;
    if (a >= QTR) return 64'd1 << 30;
    x    = (longint'(a) * PI_Q30 + 64'd90) / 180;
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    sum  = x;
    for (int unsigned n = 1; n <= 10; n++) begin
      term = (term * x2 + (64'd1 << 29)) >> 30;
      term = div_pair(n, term);
      if (n[0]) sum = sum - term;
      else      sum = sum + term;
    end
    if (sum > (64'd1 << 30)) sum = 64'd1 << 30;
    return sum;
  endfunction

  function automatic sine_tab_t sine_table(input int frac);
    sine_tab_t       tab;
    longint unsigned m;
    for (int q = 0; q <= QTR; q++) begin
      m      = quarter_sine_q30(q);
      m      = (m + (64'd1 << (29 - frac))) >> (30 - frac);
      tab[q] = m[SINE_W_MAX-1:0];
    end
    return tab;
  endfunction

  // Fold an angle in -360..450 onto the first quadrant plus a sign
  function automatic sine_sel_t fold_angle(input logic signed [ANG_W-1:0] d);
    logic signed [ANG_W-1:0] a;
    logic signed [ANG_W-1:0] t;
    sine_sel_t               s;
    a = d;
    if (d < 0) a = d + ANG_W'(YAW_LIM);
    else if (d >= YAW_LIM) a = d - ANG_W'(YAW_LIM);
    s.neg = 1'b0;
    if (a <= QTR) begin
      t = a;
    end else if (a <= HALF_TURN) begin
      t = ANG_W'(HALF_TURN) - a;
    end else if (a <= THREE_QTR) begin
      t     = a - ANG_W'(HALF_TURN);
      s.neg = 1'b1;
    end else begin
      t     = ANG_W'(YAW_LIM) - a;
      s.neg = 1'b1;
    end
    s.idx = t[6:0];
    return s;
  endfunction

endpackage

// ----- src/orbit_camera_controller.sv -----
// Channel   Handshake               Payload
// in        in_valid / in_ready     req_type, mouse_x, mouse_y, zoom_step
// out       out_valid / out_ready   pos_x, pos_y, pos_z, yaw_now, pitch_now, radius_now
// cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A request updates the camera state in its accept cycle, then a 10-word microprogram
// runs on one shared multiplier: yaw wrap (3 steps, the last two skipped when yaw is
// within +-360), sine lookup, five products, emit.
// Reset is synchronous: home registers go to 0 / 90 / 1000 and the state to those values.
// The result waits in the output register; a new request is accepted as soon as the
// sequencer is idle, and the sequencer holds on its emit step while that register is full and unread.
module orbit_camera_controller import orb_pkg::*; #(
  parameter int COORD_BITS     = COORD_BITS_DEF,
  parameter int SINE_FRAC_BITS = SINE_FRAC_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [REQ_W-1:0]         req_type,
  input  logic [COORD_BITS-1:0]    mouse_x,
  input  logic [COORD_BITS-1:0]    mouse_y,
  input  logic signed [STEP_W-1:0] zoom_step,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [POS_W-1:0]  pos_x,
  output logic signed [POS_W-1:0]  pos_y,
  output logic signed [POS_W-1:0]  pos_z,
  output logic signed [YAW_W-1:0]  yaw_now,
  output logic [PITCH_W-1:0]       pitch_now,
  output logic [RAD_W-1:0]         radius_now,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  ctl_t  ctl;
  stat_t stat;
  logic  start;
  logic  hold;
  logic  emit;

  logic signed [POS_W-1:0] pos_x_res;
  logic signed [POS_W-1:0] pos_y_res;
  logic signed [POS_W-1:0] pos_z_res;
  logic signed [YAW_W-1:0] yaw_cur;
  logic [PITCH_W-1:0]      pitch_cur;
  logic [RAD_W-1:0]        radius_cur;

  assign in_ready  = !ctl.active && !rst;
  assign cfg_ready = !ctl.active && !rst;
  assign start     = in_valid && in_ready;
  assign hold      = out_valid && !out_ready;
  assign emit      = ctl.active && (ctl.op == OP_EMIT) && !hold;

  orb_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .hold  (hold),
    .stat  (stat),
    .ctl   (ctl)
  );

  orb_datapath #(
    .COORD_BITS     (COORD_BITS),
    .SINE_FRAC_BITS (SINE_FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .req        (req_t'(req_type)),
    .mouse_x    (mouse_x),
    .mouse_y    (mouse_y),
    .zoom_step  (zoom_step),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .ctl        (ctl),
    .stat       (stat),
    .pos_x_res  (pos_x_res),
    .pos_y_res  (pos_y_res),
    .pos_z_res  (pos_z_res),
    .yaw_cur    (yaw_cur),
    .pitch_cur  (pitch_cur),
    .radius_cur (radius_cur)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pos_x      <= pos_x_res;
      pos_y      <= pos_y_res;
      pos_z      <= pos_z_res;
      yaw_now    <= yaw_cur;
      pitch_now  <= pitch_cur;
      radius_now <= radius_cur;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted but sequencer did not start");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(emit))
    else $error("result raised without an emit step");

endmodule

// ----- src/orb_sequencer.sv -----
module orb_sequencer import orb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  hold,
  input  stat_t stat,
  output ctl_t  ctl
);

  logic   busy;
  logic   busy_next;
  upc_t   upc;
  upc_t   upc_next;
  uword_t uw;

  assign uw = ucode(upc);

  always_comb begin
    busy_next = busy;
    upc_next  = upc;
    if (start) begin
      busy_next = 1'b1;
      upc_next  = UPC_RED_MUL;
    end else if (busy) begin
      if (uw.jmp == JMP_YAW_OK && stat.yaw_in_range) begin
        upc_next = uw.target;
      end else if (uw.last) begin
        // stay on the last word until the output register frees up
        if (!hold) busy_next = 1'b0;
      end else begin
        upc_next = upc + upc_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      upc  <= UPC_RED_MUL;
    end else begin
      busy <= busy_next;
      upc  <= upc_next;
    end
  end

  assign ctl.active = busy;
  assign ctl.op     = busy ? uw.op : OP_NOP;

  a_upc_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> upc <= UPC_LAST)
    else $error("step counter ran past the control store");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("request started while the sequencer was busy");

endmodule

// ----- src/orb_datapath.sv -----
module orb_datapath import orb_pkg::*; #(
  parameter int COORD_BITS     = COORD_BITS_DEF,
  parameter int SINE_FRAC_BITS = SINE_FRAC_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  req_t                        req,
  input  logic [COORD_BITS-1:0]       mouse_x,
  input  logic [COORD_BITS-1:0]       mouse_y,
  input  logic signed [STEP_W-1:0]    zoom_step,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data,
  input  ctl_t                        ctl,
  output stat_t                       stat,
  output logic signed [POS_W-1:0]     pos_x_res,
  output logic signed [POS_W-1:0]     pos_y_res,
  output logic signed [POS_W-1:0]     pos_z_res,
  output logic signed [YAW_W-1:0]     yaw_cur,
  output logic [PITCH_W-1:0]          pitch_cur,
  output logic [RAD_W-1:0]            radius_cur
);

  localparam int Y_W       = ((COORD_BITS > YAW_W) ? COORD_BITS : YAW_W) + 2;
  localparam int V_W       = Y_W - 1;
  localparam int MAG_W     = SINE_FRAC_BITS + 1;
  localparam int PP_W      = 2 * SINE_FRAC_BITS + 1;
  localparam int PX_W      = PP_W + RAD_W;
  localparam int PY_W      = MAG_W + RAD_W;
  localparam int MA_W      = (PP_W > V_W) ? PP_W : V_W;
  localparam int MB_W      = (MAG_W > RAD_W) ? MAG_W : RAD_W;
  localparam int P_W       = MA_W + MB_W;
  localparam int ZR_W      = 22;
  localparam int RED_SHIFT = 24;
  localparam logic [RAD_W-1:0] RED_RECIP = RAD_W'((1 << RED_SHIFT) / YAW_LIM);
  localparam sine_tab_t SINE_TAB = sine_table(SINE_FRAC_BITS);

  // configuration
  logic signed [YAW_W-1:0] home_yaw;
  logic [PITCH_W-1:0]      home_pitch;
  logic [RAD_W-1:0]        home_radius;

  // camera state
  logic signed [Y_W-1:0]   yaw;
  logic [PITCH_W-1:0]      pitch_deg;
  logic [RAD_W-1:0]        radius;
  logic [COORD_BITS-1:0]   last_x;
  logic [COORD_BITS-1:0]   last_y;

  // work registers
  logic [V_W-1:0]          red_q;
  logic [V_W-1:0]          red_rem;
  logic [MAG_W-1:0]        sp_mag;
  logic [MAG_W-1:0]        cp_mag;
  logic [MAG_W-1:0]        sy_mag;
  logic [MAG_W-1:0]        cy_mag;
  logic                    sp_neg;
  logic                    cp_neg;
  logic                    sy_neg;
  logic                    cy_neg;
  logic [PP_W-1:0]         pa;
  logic [PP_W-1:0]         pb;
  logic [PX_W-1:0]         px;
  logic [PX_W-1:0]         pz;
  logic [PY_W-1:0]         py;

  // event arithmetic
  logic signed [Y_W-1:0]   dx;
  logic signed [Y_W-1:0]   dy;
  logic signed [Y_W-1:0]   yaw_raw;
  logic signed [Y_W-1:0]   pitch_raw;
  logic [PITCH_W-1:0]      pitch_clamp;
  logic signed [ZR_W-1:0]  zoom_w;
  logic signed [ZR_W-1:0]  rad_raw;
  logic [RAD_W-1:0]        rad_clamp;
  logic signed [Y_W-1:0]   yaw_home;
  logic [PITCH_W-1:0]      pitch_home;
  logic [RAD_W-1:0]        rad_home;

  assign dx        = Y_W'($signed({1'b0, mouse_x})) - Y_W'($signed({1'b0, last_x}));
  assign dy        = Y_W'($signed({1'b0, mouse_y})) - Y_W'($signed({1'b0, last_y}));
  assign yaw_raw   = yaw - dx;
  assign pitch_raw = Y_W'($signed({1'b0, pitch_deg})) - dy;

  always_comb begin
    if (pitch_raw < PITCH_MIN)      pitch_clamp = PITCH_W'(PITCH_MIN);
    else if (pitch_raw > PITCH_MAX) pitch_clamp = PITCH_W'(PITCH_MAX);
    else                            pitch_clamp = pitch_raw[PITCH_W-1:0];
  end

  assign zoom_w  = ZR_W'(zoom_step);
  assign rad_raw = ZR_W'($signed({1'b0, radius})) - ((zoom_w <<< 3) + (zoom_w <<< 1));

  always_comb begin
    if (rad_raw < RAD_MIN)      rad_clamp = RAD_W'(RAD_MIN);
    else if (rad_raw > RAD_MAX) rad_clamp = RAD_W'(RAD_MAX);
    else                        rad_clamp = rad_raw[RAD_W-1:0];
  end

  always_comb begin
    if (home_yaw > YAW_LIM)       yaw_home = Y_W'(YAW_LIM);
    else if (home_yaw < -YAW_LIM) yaw_home = Y_W'(-YAW_LIM);
    else                          yaw_home = Y_W'(home_yaw);
    if (home_pitch < PITCH_W'(PITCH_MIN))      pitch_home = PITCH_W'(PITCH_MIN);
    else if (home_pitch > PITCH_W'(PITCH_MAX)) pitch_home = PITCH_W'(PITCH_MAX);
    else                                       pitch_home = home_pitch;
    rad_home = (home_radius == '0) ? RAD_W'(RAD_MIN) : home_radius;
  end

  // yaw wrap: v = |yaw| - 361, q = v / 360 by reciprocal, one correction
  logic                    yaw_neg;
  logic [Y_W-1:0]          yaw_abs_w;
  logic [V_W-1:0]          red_v;
  logic [V_W-1:0]          q360;
  logic [V_W-1:0]          rem_fix;
  logic [V_W-1:0]          red_mag;
  logic signed [Y_W-1:0]   yaw_fixed;

  assign yaw_neg   = yaw[Y_W-1];
  assign yaw_abs_w = yaw_neg ? Y_W'(0) - yaw : yaw;
  assign red_v     = yaw_abs_w[V_W-1:0] - V_W'(YAW_LIM + 1);
  assign q360      = (red_q << 8) + (red_q << 6) + (red_q << 5) + (red_q << 3);
  assign rem_fix   = (red_rem >= V_W'(YAW_LIM)) ? red_rem - V_W'(YAW_LIM) : red_rem;
  assign red_mag   = rem_fix + V_W'(1);
  assign yaw_fixed = yaw_neg ? Y_W'(0) - Y_W'(red_mag) : Y_W'(red_mag);

  assign stat.yaw_in_range = (yaw >= -YAW_LIM) && (yaw <= YAW_LIM);

  // sine lookups
  logic signed [ANG_W-1:0] yaw_ang;
  logic signed [ANG_W-1:0] pitch_ang;
  sine_sel_t               sp_sel;
  sine_sel_t               cp_sel;
  sine_sel_t               sy_sel;
  sine_sel_t               cy_sel;

  assign yaw_ang   = yaw[ANG_W-1:0];
  assign pitch_ang = ANG_W'(pitch_deg);
  assign sp_sel    = fold_angle(pitch_ang);
  assign cp_sel    = fold_angle(pitch_ang + ANG_W'(QTR));
  assign sy_sel    = fold_angle(yaw_ang);
  assign cy_sel    = fold_angle(yaw_ang + ANG_W'(QTR));

  // shared multiplier
  logic [MA_W-1:0] mul_a;
  logic [MB_W-1:0] mul_b;
  logic [P_W-1:0]  mul_p;
  logic [P_W-1:0]  q_full;

  always_comb begin
    case (ctl.op)
      OP_RED_MUL: begin
        mul_a = MA_W'(red_v);
        mul_b = MB_W'(RED_RECIP);
      end
      OP_MUL_SPSY: begin
        mul_a = MA_W'(sp_mag);
        mul_b = MB_W'(sy_mag);
      end
      OP_MUL_SPCY: begin
        mul_a = MA_W'(sp_mag);
        mul_b = MB_W'(cy_mag);
      end
      OP_MUL_X: begin
        mul_a = MA_W'(pa);
        mul_b = MB_W'(radius);
      end
      OP_MUL_Z: begin
        mul_a = MA_W'(pb);
        mul_b = MB_W'(radius);
      end
      OP_MUL_Y: begin
        mul_a = MA_W'(cp_mag);
        mul_b = MB_W'(radius);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p  = P_W'(mul_a) * P_W'(mul_b);
  assign q_full = mul_p >> RED_SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      home_yaw    <= YAW_W'(HOME_YAW_DEF);
      home_pitch  <= PITCH_W'(HOME_PITCH_DEF);
      home_radius <= RAD_W'(HOME_RADIUS_DEF);
      yaw         <= Y_W'(HOME_YAW_DEF);
      pitch_deg   <= PITCH_W'(HOME_PITCH_DEF);
      radius      <= RAD_W'(HOME_RADIUS_DEF);
      last_x      <= '0;
      last_y      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_HOME_YAW:    home_yaw    <= cfg_data[YAW_W-1:0];
          CFG_HOME_PITCH:  home_pitch  <= cfg_data[PITCH_W-1:0];
          CFG_HOME_RADIUS: home_radius <= cfg_data[RAD_W-1:0];
          default: ;
        endcase
      end
      if (start) begin
        case (req)
          REQ_MOVE: begin
            // a zero stored coordinate means no drag in progress
            if (last_x != '0 && last_y != '0) begin
              yaw       <= yaw_raw;
              pitch_deg <= pitch_clamp;
            end
            last_x <= mouse_x;
            last_y <= mouse_y;
          end
          REQ_RELEASE: begin
            last_x <= '0;
            last_y <= '0;
          end
          REQ_ZOOM: radius <= rad_clamp;
          REQ_HOME: begin
            yaw       <= yaw_home;
            pitch_deg <= pitch_home;
            radius    <= rad_home;
          end
          default: ;
        endcase
      end else if (ctl.op == OP_RED_FIX) begin
        yaw <= yaw_fixed;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_RED_MUL:  red_q   <= q_full[V_W-1:0];
      OP_RED_SUB:  red_rem <= red_v - q360;
      OP_LOOKUP: begin
        sp_mag <= SINE_TAB[sp_sel.idx][MAG_W-1:0];
        cp_mag <= SINE_TAB[cp_sel.idx][MAG_W-1:0];
        sy_mag <= SINE_TAB[sy_sel.idx][MAG_W-1:0];
        cy_mag <= SINE_TAB[cy_sel.idx][MAG_W-1:0];
        sp_neg <= sp_sel.neg;
        cp_neg <= cp_sel.neg;
        sy_neg <= sy_sel.neg;
        cy_neg <= cy_sel.neg;
      end
      OP_MUL_SPSY: pa <= mul_p[PP_W-1:0];
      OP_MUL_SPCY: pb <= mul_p[PP_W-1:0];
      OP_MUL_X:    px <= mul_p[PX_W-1:0];
      OP_MUL_Z:    pz <= mul_p[PX_W-1:0];
      OP_MUL_Y:    py <= mul_p[PY_W-1:0];
      default: ;
    endcase
  end

  // round magnitudes half away from zero, then apply sign
  logic [PX_W-1:0]  rx_sum;
  logic [PX_W-1:0]  rz_sum;
  logic [PY_W-1:0]  ry_sum;
  logic [POS_W-1:0] rx_mag;
  logic [POS_W-1:0] rz_mag;
  logic [POS_W-1:0] ry_mag;
  logic             x_neg;
  logic             z_neg;

  assign rx_sum = px + (PX_W'(1) << (2 * SINE_FRAC_BITS - 1));
  assign rz_sum = pz + (PX_W'(1) << (2 * SINE_FRAC_BITS - 1));
  assign ry_sum = py + (PY_W'(1) << (SINE_FRAC_BITS - 1));
  assign rx_mag = rx_sum[2 * SINE_FRAC_BITS +: POS_W];
  assign rz_mag = rz_sum[2 * SINE_FRAC_BITS +: POS_W];
  assign ry_mag = ry_sum[SINE_FRAC_BITS +: POS_W];
  assign x_neg  = sp_neg ^ sy_neg;
  assign z_neg  = sp_neg ^ cy_neg;

  assign pos_x_res  = x_neg  ? POS_W'(0) - rx_mag : rx_mag;
  assign pos_z_res  = z_neg  ? POS_W'(0) - rz_mag : rz_mag;
  assign pos_y_res  = cp_neg ? POS_W'(0) - ry_mag : ry_mag;
  assign yaw_cur    = yaw[YAW_W-1:0];
  assign pitch_cur  = pitch_deg;
  assign radius_cur = radius;

  a_yaw_wrapped: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == OP_RED_FIX) |=> (yaw >= -YAW_LIM) && (yaw <= YAW_LIM))
    else $error("yaw wrap left yaw outside +-360");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    (pitch_deg >= PITCH_W'(PITCH_MIN)) && (pitch_deg <= PITCH_W'(PITCH_MAX)))
    else $error("pitch left 1..177");

endmodule

// ----- dv/orbit_camera_controller_tb.sv -----
module orbit_camera_controller_tb;
  import orb_pkg::*;

  localparam int FRAC = SINE_FRAC_DEF;
  localparam longint unsigned PI_FX30 = 64'd3373259426;
  localparam int N_PHASES = 7;
  localparam int PHASE_ITEMS = 96;
  localparam int STALL_LEN = 200;
  localparam int SETTLE = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] pz;
    logic signed [YAW_W-1:0] yaw;
    logic [PITCH_W-1:0]      pitch;
    logic [RAD_W-1:0]        rad;
  } cam_pose_t;

  typedef struct {
    req_t                     req;
    logic [COORD_BITS_DEF-1:0] mx;
    logic [COORD_BITS_DEF-1:0] my;
    logic signed [STEP_W-1:0] zs;
    bit                       typed;
    cam_pose_t                want;
  } dir_row_t;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic [REQ_W-1:0]          req_type;
  logic [COORD_BITS_DEF-1:0] mouse_x;
  logic [COORD_BITS_DEF-1:0] mouse_y;
  logic signed [STEP_W-1:0]  zoom_step;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [POS_W-1:0]   pos_x;
  logic signed [POS_W-1:0]   pos_y;
  logic signed [POS_W-1:0]   pos_z;
  logic signed [YAW_W-1:0]   yaw_now;
  logic [PITCH_W-1:0]        pitch_now;
  logic [RAD_W-1:0]          radius_now;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_W-1:0]          cfg_data;

  // camera model state
  int cam_yaw;
  int cam_pitch;
  int cam_radius;
  int prev_mx;
  int prev_my;
  int home_yaw_r;
  int home_pitch_r;
  int home_radius_r;
  longint sin_tab [0:QTR];

  cam_pose_t pending_poses[$];
  dir_row_t  dir_tab[$];

  bit calm;
  bit hold_output;
  int mismatches;
  int results_checked;
  int moves_applied;
  int yaw_wraps;
  int cfg_writes;
  int req_count [4];
  int cycles;

  orbit_camera_controller dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .mouse_x(mouse_x), .mouse_y(mouse_y), .zoom_step(zoom_step),
    .out_valid(out_valid), .out_ready(out_ready),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .yaw_now(yaw_now), .pitch_now(pitch_now), .radius_now(radius_now),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Q30 sine of 0..90 degrees, Taylor series with per-term rounding
  function automatic longint unsigned qsin_q30(input int unsigned a);
    longint unsigned x, x2, term, acc, d;
    if (a == 0) return 64'd0;
    if (a >= QTR) return 64'd1 << 30;
    x = (longint'(a) * PI_FX30 + 64'd90) / 64'd180;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    acc = x;
    for (int unsigned n = 1; n <= 10; n++) begin
      d = 64'(2 * n) * 64'(2 * n + 1);
      term = (term * x2 + (64'd1 << 29)) >> 30;
      term = (term + d / 2) / d;
      if (n % 2 == 1) acc = acc - term;
      else acc = acc + term;
    end
    if (acc > (64'd1 << 30)) acc = 64'd1 << 30;
    return acc;
  endfunction

  function automatic longint sine_q15(input int deg);
    int a;
    int q;
    bit neg;
    a = deg % YAW_LIM;
    if (a < 0) a += YAW_LIM;
    neg = 1'b0;
    if (a <= QTR) begin
      q = a;
    end else if (a <= HALF_TURN) begin
      q = HALF_TURN - a;
    end else if (a <= THREE_QTR) begin
      q = a - HALF_TURN;
      neg = 1'b1;
    end else begin
      q = YAW_LIM - a;
      neg = 1'b1;
    end
    return neg ? -sin_tab[q] : sin_tab[q];
  endfunction

  function automatic longint round_half_away(input longint v, input int sh);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (longint'(1) << (sh - 1))) >> sh;
    return (v < 0) ? -m : m;
  endfunction

  function automatic int clampi(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // apply one request to the camera state and return the pose it reports
  function automatic cam_pose_t advance_camera(input req_t r, input int mx, input int my,
                                               input int zs);
    int y, p;
    longint sp, cp, sy, cy, rad;
    cam_pose_t o;
    case (r)
      REQ_MOVE: begin
        // turning needs a stored position on both axes
        if (prev_mx != 0 && prev_my != 0) begin
          y = cam_yaw - (mx - prev_mx);
          p = cam_pitch - (my - prev_my);
          if (y > YAW_LIM) begin
            y = ((y - (YAW_LIM + 1)) % YAW_LIM) + 1;
            yaw_wraps++;
          end else if (y < -YAW_LIM) begin
            y = -(((-y - (YAW_LIM + 1)) % YAW_LIM) + 1);
            yaw_wraps++;
          end
          cam_yaw = y;
          cam_pitch = clampi(p, PITCH_MIN, PITCH_MAX);
          moves_applied++;
        end
        prev_mx = mx;
        prev_my = my;
      end
      REQ_RELEASE: begin
        prev_mx = 0;
        prev_my = 0;
      end
      REQ_ZOOM: cam_radius = clampi(cam_radius - 10 * zs, RAD_MIN, RAD_MAX);
      default: begin
        cam_yaw = clampi(home_yaw_r, -YAW_LIM, YAW_LIM);
        cam_pitch = clampi(home_pitch_r, PITCH_MIN, PITCH_MAX);
        cam_radius = clampi(home_radius_r, RAD_MIN, RAD_MAX);
      end
    endcase
    sp = sine_q15(cam_pitch);
    cp = sine_q15(cam_pitch + QTR);
    sy = sine_q15(cam_yaw);
    cy = sine_q15(cam_yaw + QTR);
    rad = longint'(cam_radius);
    o.px = POS_W'(round_half_away(sp * sy * rad, 2 * FRAC));
    o.py = POS_W'(round_half_away(cp * rad, FRAC));
    o.pz = POS_W'(round_half_away(sp * cy * rad, 2 * FRAC));
    o.yaw = YAW_W'(cam_yaw);
    o.pitch = PITCH_W'(cam_pitch);
    o.rad = RAD_W'(cam_radius);
    return o;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH @%0d: %s", cycles, msg);
  endtask

  task automatic check_pose(input cam_pose_t got);
    cam_pose_t want;
    if (pending_poses.size() == 0) begin
      flag_mismatch($sformatf("unexpected result yaw %0d pitch %0d radius %0d",
                              got.yaw, got.pitch, got.rad));
      return;
    end
    want = pending_poses.pop_front();
    results_checked++;
    if (got.px !== want.px) flag_mismatch($sformatf("pos_x %0d want %0d", got.px, want.px));
    if (got.py !== want.py) flag_mismatch($sformatf("pos_y %0d want %0d", got.py, want.py));
    if (got.pz !== want.pz) flag_mismatch($sformatf("pos_z %0d want %0d", got.pz, want.pz));
    if (got.yaw !== want.yaw)
      flag_mismatch($sformatf("yaw_now %0d want %0d", got.yaw, want.yaw));
    if (got.pitch !== want.pitch)
      flag_mismatch($sformatf("pitch_now %0d want %0d", got.pitch, want.pitch));
    if (got.rad !== want.rad)
      flag_mismatch($sformatf("radius_now %0d want %0d", got.rad, want.rad));
  endtask

  // valid stays high into the next request when there is no gap
  task automatic send_request(input req_t r, input logic [COORD_BITS_DEF-1:0] mx,
                              input logic [COORD_BITS_DEF-1:0] my,
                              input logic signed [STEP_W-1:0] zs,
                              input bit typed, input cam_pose_t want);
    int gap;
    cam_pose_t pose;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= r;
    mouse_x <= mx;
    mouse_y <= my;
    zoom_step <= zs;
    do @(posedge clk); while (!in_ready);
    pose = advance_camera(r, int'(mx), int'(my), int'(zs));
    pending_poses.push_back(typed ? want : pose);
    req_count[r]++;
  endtask

  task automatic write_home(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_HOME_YAW:    home_yaw_r = $signed(data[YAW_W-1:0]);
      CFG_HOME_PITCH:  home_pitch_r = data[PITCH_W-1:0];
      CFG_HOME_RADIUS: home_radius_r = data[RAD_W-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  // stop offering and wait until every request has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk);
  endtask

  // result side: random back-pressure, one long hold-off on demand
  initial begin
    int gap;
    out_ready = 1'b0;
    gap = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        check_pose(cam_pose_t'{pos_x, pos_y, pos_z, yaw_now, pitch_now, radius_now});
        gap = calm ? 0 : $urandom_range(0, 7);
      end else if (!out_ready && gap > 0) begin
        gap--;
      end
      if (hold_output) begin
        hold_output = 1'b0;
        gap = STALL_LEN;
      end
      out_ready <= (gap == 0);
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles,
             pending_poses.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    cam_pose_t home_pose;
    cam_pose_t no_pose;
    req_t r;
    logic [COORD_BITS_DEF-1:0] mx, my;
    logic signed [STEP_W-1:0] zs;
    int roll, sub, delta;

    rst = 1'b1;
    in_valid = 1'b0;
    req_type = '0;
    mouse_x = '0;
    mouse_y = '0;
    zoom_step = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 1'b0;
    hold_output = 1'b0;
    mismatches = 0;
    results_checked = 0;
    moves_applied = 0;
    yaw_wraps = 0;
    cfg_writes = 0;
    foreach (req_count[i]) req_count[i] = 0;

    for (int q = 0; q <= QTR; q++)
      sin_tab[q] = longint'((qsin_q30(q) + (64'd1 << (29 - FRAC))) >> (30 - FRAC));

    home_yaw_r = HOME_YAW_DEF;
    home_pitch_r = HOME_PITCH_DEF;
    home_radius_r = HOME_RADIUS_DEF;
    cam_yaw = HOME_YAW_DEF;
    cam_pitch = HOME_PITCH_DEF;
    cam_radius = HOME_RADIUS_DEF;
    prev_mx = 0;
    prev_my = 0;

    home_pose = '{0, 0, 1000, 0, 90, 1000};
    no_pose = '{default: 0};

    // reset pose, moves without a stored position, radius limits, home reload
    dir_tab.push_back(dir_row_t'{REQ_RELEASE, 12'd0, 12'd0, 16'sd0, 1'b1, home_pose});
    dir_tab.push_back(dir_row_t'{REQ_MOVE, 12'd0, 12'd0, 16'sd0, 1'b1, home_pose});
    dir_tab.push_back(dir_row_t'{REQ_MOVE, 12'hFFF, 12'hFFF, 16'sd0, 1'b1, home_pose});
    dir_tab.push_back(dir_row_t'{REQ_ZOOM, 12'd0, 12'd0, 16'sh7FFF, 1'b1,
                                 '{0, 0, 1, 0, 90, 1}});
    dir_tab.push_back(dir_row_t'{REQ_ZOOM, 12'd0, 12'd0, 16'sh8000, 1'b1,
                                 '{0, 0, 65535, 0, 90, 65535}});
    dir_tab.push_back(dir_row_t'{REQ_ZOOM, 12'd0, 12'd0, 16'sd0, 1'b1,
                                 '{0, 0, 65535, 0, 90, 65535}});
    dir_tab.push_back(dir_row_t'{REQ_ZOOM, 12'd0, 12'd0, 16'sd1, 1'b1,
                                 '{0, 0, 65525, 0, 90, 65525}});
    dir_tab.push_back(dir_row_t'{REQ_HOME, 12'd0, 12'd0, 16'sd0, 1'b1, home_pose});
    // stored position survives home; large deltas wrap yaw and clamp pitch
    dir_tab.push_back(dir_row_t'{REQ_MOVE, 12'd0, 12'hFFF, 16'sd0, 1'b0, no_pose});
    dir_tab.push_back(dir_row_t'{REQ_MOVE, 12'd2048, 12'd2048, 16'sd0, 1'b0, no_pose});
    dir_tab.push_back(dir_row_t'{REQ_MOVE, 12'hFFF, 12'hFFF, 16'sd0, 1'b0, no_pose});
    dir_tab.push_back(dir_row_t'{REQ_MOVE, 12'd1, 12'd1, 16'sd0, 1'b0, no_pose});
    dir_tab.push_back(dir_row_t'{REQ_MOVE, 12'd2, 12'd0, 16'sd0, 1'b0, no_pose});
    dir_tab.push_back(dir_row_t'{REQ_MOVE, 12'd5, 12'd5, 16'sd0, 1'b0, no_pose});
    dir_tab.push_back(dir_row_t'{REQ_MOVE, 12'd365, 12'd5, 16'sd0, 1'b0, no_pose});
    dir_tab.push_back(dir_row_t'{REQ_MOVE, 12'd5, 12'd50, 16'sd0, 1'b0, no_pose});
    dir_tab.push_back(dir_row_t'{REQ_ZOOM, 12'd0, 12'd0, -16'sd100, 1'b0, no_pose});
    dir_tab.push_back(dir_row_t'{REQ_ZOOM, 12'hAAA, 12'h555, 16'sh5555, 1'b0, no_pose});
    dir_tab.push_back(dir_row_t'{REQ_ZOOM, 12'h555, 12'hAAA, 16'shAAAA, 1'b0, no_pose});
    dir_tab.push_back(dir_row_t'{REQ_RELEASE, 12'hFFF, 12'hFFF, 16'shFFFF, 1'b0, no_pose});
    dir_tab.push_back(dir_row_t'{REQ_MOVE, 12'hAAA, 12'h555, 16'sd0, 1'b0, no_pose});
    dir_tab.push_back(dir_row_t'{REQ_MOVE, 12'h555, 12'hAAA, 16'sd0, 1'b0, no_pose});
    dir_tab.push_back(dir_row_t'{REQ_HOME, 12'hFFF, 12'd0, 16'sh7FFF, 1'b1, home_pose});

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i])
      send_request(dir_tab[i].req, dir_tab[i].mx, dir_tab[i].my, dir_tab[i].zs,
                   dir_tab[i].typed, dir_tab[i].want);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_results();
      repeat (SETTLE) @(posedge clk);
      // home settings: below range, above range, both exact limits, then random
      case (ph)
        0: begin
          write_home(CFG_HOME_YAW, 16'h0200);
          write_home(CFG_HOME_PITCH, 16'h0000);
          write_home(CFG_HOME_RADIUS, 16'h0000);
        end
        1: begin
          write_home(CFG_HOME_YAW, 16'hFDFF);
          write_home(CFG_HOME_PITCH, 16'hAAFF);
          write_home(CFG_HOME_RADIUS, 16'hFFFF);
        end
        2: begin
          write_home(CFG_HOME_YAW, 16'h0298);
          write_home(CFG_HOME_PITCH, 16'h0001);
          write_home(CFG_HOME_RADIUS, 16'h0001);
        end
        3: begin
          write_home(CFG_HOME_YAW, 16'h0168);
          write_home(CFG_HOME_PITCH, 16'h00B1);
          write_home(CFG_HOME_RADIUS, 16'hFFFF);
        end
        default: begin
          write_home(CFG_HOME_RADIUS, CFG_W'($urandom_range(0, 65535)));
          write_home(CFG_HOME_YAW, CFG_W'($urandom_range(0, 65535)));
          write_home(CFG_HOME_PITCH, CFG_W'($urandom_range(0, 65535)));
        end
      endcase
      write_home(CFG_SPARE, CFG_W'($urandom_range(0, 65535)));
      cfg_valid <= 1'b0;
      calm = (ph == 3);

      send_request(REQ_HOME, 12'd0, 12'd0, 16'sd0, 1'b0, no_pose);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 1 && i == 30) hold_output = 1'b1;
        if (ph == 2 && i == 50) drain_results();
        roll = $urandom_range(0, 99);
        mx = '0;
        my = '0;
        zs = '0;
        if (roll < 60) begin
          r = REQ_MOVE;
          sub = $urandom_range(0, 9);
          if (sub == 0) begin
            mx = 12'($urandom_range(0, 4095));
            my = 12'($urandom_range(0, 4095));
          end else if (sub == 1) begin
            mx = $urandom_range(0, 1) ? 12'd0 : 12'($urandom_range(0, 4095));
            my = (mx != 0) ? 12'd0 : 12'($urandom_range(0, 4095));
          end else if (sub == 2) begin
            mx = $urandom_range(0, 1) ? 12'hFFF : 12'h001;
            my = $urandom_range(0, 1) ? 12'hFFF : 12'h001;
          end else begin
            // small drags keep the camera off its limits most of the time
            delta = $urandom_range(0, 60);
            mx = 12'(clampi(prev_mx + delta - 30, 1, 4095));
            delta = $urandom_range(0, 60);
            my = 12'(clampi(prev_my + delta - 30, 1, 4095));
          end
        end else if (roll < 70) begin
          r = REQ_RELEASE;
          mx = 12'($urandom_range(0, 4095));
        end else if (roll < 90) begin
          r = REQ_ZOOM;
          if ($urandom_range(0, 4) == 0) begin
            zs = 16'($urandom_range(0, 65535));
          end else begin
            delta = $urandom_range(0, 400);
            zs = 16'(delta - 200);
          end
        end else begin
          r = REQ_HOME;
          zs = 16'($urandom_range(0, 65535));
        end
        send_request(r, mx, my, zs, 1'b0, no_pose);
      end
    end

    drain_results();
    repeat (SETTLE) @(posedge clk);

    $display("%0d requests: %0d moves (%0d turned the camera, %0d yaw wraps),",
             req_count[0] + req_count[1] + req_count[2] + req_count[3], req_count[REQ_MOVE],
             moves_applied, yaw_wraps);
    $display("  %0d releases, %0d zooms, %0d home loads",
             req_count[REQ_RELEASE], req_count[REQ_ZOOM], req_count[REQ_HOME]);
    $display("%0d register writes over %0d home settings, %0d results checked, %0d mismatches",
             cfg_writes, N_PHASES, results_checked, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- orbit_camera_controller.f -----
src/orb_pkg.sv
src/orb_sequencer.sv
src/orb_datapath.sv
src/orbit_camera_controller.sv
dv/orbit_camera_controller_tb.sv
